/* src/mpqt_pkg.sv */
// Shared types and codes for the tie-breaking max-priority queue.
package mpqt_pkg;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_PEEK = 2'd1;
  localparam logic [1:0] OP_POP  = 2'd2;
  localparam logic [1:0] OP_RSVD = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int KEY_W = 64;
  typedef logic [KEY_W-1:0] key_t;

  // Larger key means higher priority; id and tag are inverted.
  function automatic key_t pack_key(logic [15:0] sc, logic [15:0] id, logic [31:0] tg);
    pack_key = {sc, ~id, ~tg};
  endfunction

endpackage

/* src/mpqt_store.sv */
// Heap entry memory: one write port, one registered read port.
module mpqt_store
  import mpqt_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  key_t          wdata,
  input  logic [AW-1:0] raddr,
  output key_t          rdata
);

  key_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/max_priority_queue_tiebreak.sv */
// Top level of the tie-breaking max-priority queue.
//
// One item in on s_axis, one result out on m_axis per item. An item is an
// opcode (push, peek, pop; the spare code acts as peek) and an entry: score,
// id and a 32-bit name tag. The result gives status and the top entry after
// the action (highest score, then smallest id, then smallest tag).
// The heap sits in a single synchronous RAM; a sequencer walks it one level
// at a time, never reading a slot in the cycle it is written.
// Peek, pop to empty and any dropped action go straight to the root read and
// the result register; push sifts up with a parent read and a compare per
// level; pop loads the last slot, then reads the left and right child per
// level of sift-down and compares them.
// One item at a time: s_axis_tready is high only when the sequencer is idle
// and the output register is empty, so a stalled receiver holds the result
// and the input until the result transfer.
// Reset clears the entry count and the output valid; RAM contents need no
// clearing since data read from slots at or above the count is never used.
module max_priority_queue_tiebreak
  import mpqt_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // score[15:0], entry_id[31:16], name_tag[63:32]
  input  logic [1:0]  s_axis_tuser,  // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // top_score, top_id, top_tag
  output logic [1:0]  m_axis_tuser   // status
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_UP_RD = 4'd1;
  localparam logic [3:0] S_UP_CK = 4'd2;
  localparam logic [3:0] S_DN_LD = 4'd3;
  localparam logic [3:0] S_DN_LV = 4'd4;
  localparam logic [3:0] S_DN_RL = 4'd5;
  localparam logic [3:0] S_DN_CK = 4'd6;
  localparam logic [3:0] S_TOPR  = 4'd7;
  localparam logic [3:0] S_TOP   = 4'd8;

  logic [3:0]    state;
  logic [CW-1:0] count;
  logic [AW:0]   pos;     // one extra bit so child index math cannot wrap
  key_t          cur;     // key being sifted
  key_t          lkey;    // left child key, held for the compare step
  logic [1:0]    st;
  logic          out_v;
  logic [63:0]   out_d;
  logic [1:0]    out_u;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  key_t          wdata, rdata;

  mpqt_store #(.DEPTH(CAPACITY), .AW(AW)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [AW:0]   parent, left, right;
  logic [AW:0]   cnt;
  logic [1:0]    op;
  logic          fire;
  logic          take_left, take_right;

  assign op     = s_axis_tuser;
  assign cnt    = (AW+1)'(count);
  assign parent = (pos - 1'b1) >> 1;
  assign left   = {pos[AW-1:0], 1'b1};
  assign right  = left + 1'b1;
  assign s_axis_tready = (state == S_IDLE) && !out_v;
  assign fire   = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = out_d;
  assign m_axis_tuser  = out_u;

  // Sift-down choice: rdata holds the right child in S_DN_CK.
  assign take_left  = lkey > cur;
  assign take_right = (right < cnt) && (rdata > (take_left ? lkey : cur));

  always_comb begin
    we = 1'b0;
    waddr = pos[AW-1:0];
    wdata = cur;
    raddr = '0;
    unique case (state)
      S_IDLE: begin
        // Fetch the last slot for a pop; it becomes the key to sift down.
        if (fire && op == OP_POP && count != '0) begin
          raddr = AW'(count - 1'b1);
        end
      end
      S_UP_RD: begin
        if (pos == '0) begin
          we = 1'b1;
        end else begin
          raddr = parent[AW-1:0];
        end
      end
      // Move the parent down, or settle the new key here.
      S_UP_CK: begin
        we = 1'b1;
        if (rdata < cur) begin
          wdata = rdata;
        end
      end
      S_DN_LV: begin
        if (left < cnt) begin
          raddr = left[AW-1:0];
        end else begin
          we = 1'b1;
        end
      end
      S_DN_RL: raddr = right[AW-1:0];
      // Move the larger child up, or settle the key here.
      S_DN_CK: begin
        we = 1'b1;
        if (take_right) begin
          wdata = rdata;
        end else if (take_left) begin
          wdata = lkey;
        end
      end
      S_TOPR: raddr = '0;
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_v <= 1'b0;
    end else begin
      if (out_v && m_axis_tready) begin
        out_v <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (fire) begin
            st <= ST_OK;
            if (op == OP_PUSH) begin
              if (count < CW'(CAPACITY)) begin
                cur   <= pack_key(s_axis_tdata[15:0], s_axis_tdata[31:16],
                                  s_axis_tdata[63:32]);
                pos   <= (AW+1)'(count);
                count <= count + 1'b1;
                state <= S_UP_RD;
              end else begin
                st    <= ST_FULL;
                state <= S_TOPR;
              end
            end else if (op == OP_POP && count != '0) begin
              count <= count - 1'b1;
              pos   <= '0;
              state <= (count == CW'(1)) ? S_TOPR : S_DN_LD;
            end else begin
              state <= S_TOPR;
            end
          end
        end
        S_UP_RD: state <= (pos == '0) ? S_TOPR : S_UP_CK;
        // Parent key valid in rdata.
        S_UP_CK: begin
          if (rdata < cur) begin
            pos   <= parent;
            state <= S_UP_RD;
          end else begin
            state <= S_TOPR;
          end
        end
        // rdata holds the old last slot, which becomes cur.
        S_DN_LD: begin
          cur   <= rdata;
          state <= S_DN_LV;
        end
        S_DN_LV: state <= (left < cnt) ? S_DN_RL : S_TOPR;
        S_DN_RL: begin
          lkey  <= rdata;
          state <= S_DN_CK;
        end
        S_DN_CK: begin
          if (take_right) begin
            pos   <= right;
            state <= S_DN_LV;
          end else if (take_left) begin
            pos   <= left;
            state <= S_DN_LV;
          end else begin
            state <= S_TOPR;
          end
        end
        S_TOPR: state <= S_TOP;
        // Root key valid in rdata; load the result register.
        S_TOP: begin
          out_v <= 1'b1;
          if (count == '0) begin
            out_u <= ST_EMPTY;
            out_d <= '0;
          end else begin
            out_u <= st;
            out_d <= {~rdata[31:0], ~rdata[47:32], rdata[63:48]};
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser));

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY));

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid);

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == ST_EMPTY |-> m_axis_tdata == '0);

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      (m_axis_tuser == ST_OK || m_axis_tuser == ST_EMPTY || m_axis_tuser == ST_FULL));

endmodule

/* tb/sv/tb_max_priority_queue_tiebreak.sv */
// Testbench for the tie-breaking max-priority queue: directed and random streams.
module tb_max_priority_queue_tiebreak;
  import mpqt_pkg::*;

  localparam int DEPTH      = 256;
  localparam int IDLE_LIMIT = 20000;
  localparam int TAIL_WAIT  = 60;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = OP_PEEK;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] score;
    logic [15:0] id;
    logic [31:0] tag;
  } top_report_t;

  // Shadow of the queue contents: unordered list of packed keys.
  key_t        held_keys[$];
  top_report_t pending_tops[$];

  int errors    = 0;
  int sent      = 0;
  int received  = 0;
  int idle_cnt  = 0;
  int full_hits = 0;
  int empty_hits = 0;
  bit recv_stall_on = 1'b1;
  bit send_gap_on   = 1'b1;

  max_priority_queue_tiebreak u_top (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Apply one operation to the shadow set and return the expected report.
  function automatic top_report_t apply_op(logic [1:0] op, logic [15:0] sc,
                                           logic [15:0] id, logic [31:0] tg);
    top_report_t rep;
    logic [1:0]  st;
    key_t        best;
    int          best_idx;
    st = ST_OK;
    if (op == OP_PUSH) begin
      if (held_keys.size() >= DEPTH) begin
        st = ST_FULL;
      end else begin
        held_keys.push_back({sc, ~id, ~tg});
      end
    end
    best = '0;
    best_idx = -1;
    foreach (held_keys[i]) begin
      if (best_idx < 0 || held_keys[i] > best) begin
        best = held_keys[i];
        best_idx = i;
      end
    end
    if (op == OP_POP && best_idx >= 0) begin
      held_keys.delete(best_idx);
      best = '0;
      best_idx = -1;
      foreach (held_keys[i]) begin
        if (best_idx < 0 || held_keys[i] > best) begin
          best = held_keys[i];
          best_idx = i;
        end
      end
    end
    if (best_idx < 0) begin
      rep = '{ST_EMPTY, 16'd0, 16'd0, 32'd0};
    end else begin
      rep = '{st, best[63:48], ~best[47:32], ~best[31:0]};
    end
    return rep;
  endfunction

  // Send one item and hold it until the transfer; record the expectation.
  // Valid stays high after the transfer until a later call gaps or the caller drops it.
  task automatic send_item(logic [1:0] op, logic [15:0] sc, logic [15:0] id,
                           logic [31:0] tg);
    int g;
    g = send_gap_on ? gap_len() : 0;
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {tg, id, sc};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_tops.push_back(apply_op(op, sc, id, tg));
    sent++;
  endtask

  task automatic send_random_push();
    send_item(OP_PUSH, 16'($urandom), 16'($urandom), $urandom);
  endtask

  // Wait until every expected report has come back.
  task automatic drain();
    while (pending_tops.size() != 0) @(posedge clk);
  endtask

  // Check each result against the oldest expectation.
  always @(posedge clk) begin
    top_report_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      received++;
      if (m_axis_tuser == ST_FULL) full_hits++;
      if (m_axis_tuser == ST_EMPTY) empty_hits++;
      if (pending_tops.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected result status=%0d data=%h",
                   m_axis_tuser, m_axis_tdata);
      end else begin
        want = pending_tops.pop_front();
        if (m_axis_tuser !== want.status || m_axis_tdata[15:0] !== want.score ||
            m_axis_tdata[31:16] !== want.id || m_axis_tdata[63:32] !== want.tag) begin
          errors++;
          if (errors <= 10)
            $display({"ERROR: result %0d exp st=%0d sc=%h id=%h tag=%h",
                      " got st=%0d sc=%h id=%h tag=%h"},
                     received, want.status, want.score, want.id, want.tag, m_axis_tuser,
                     m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[63:32]);
        end
      end
    end
  end

  // Random receiver stalls; held ready when stalls are switched off.
  always @(posedge clk) begin
    if (rst || !recv_stall_on) begin
      m_axis_tready <= 1'b1;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:69]:  m_axis_tready <= 1'b1;
        [70:96]: m_axis_tready <= 1'b0;
        default: m_axis_tready <= 1'b0;
      endcase
    end
  end

  // Watchdog on cycles with no transfer on either side.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Extremes of the fields on an empty queue, then drain back to empty.
  task automatic test_empty_and_extremes();
    send_item(OP_PEEK, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF);
    send_item(OP_POP, 16'h0, 16'h0, 32'h0);
    send_item(OP_RSVD, 16'h1234, 16'h5678, 32'h9ABCDEF0);
    send_item(OP_PUSH, 16'h0000, 16'h0000, 32'h00000000);
    send_item(OP_PUSH, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF);
    send_item(OP_PEEK, 16'hAAAA, 16'h5555, 32'hA5A5A5A5);
    send_item(OP_POP, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF);
    send_item(OP_POP, 16'h0, 16'h0, 32'h0);
    send_item(OP_POP, 16'h0, 16'h0, 32'h0);
  endtask

  // Equal scores: smaller id first; equal score and id: smaller tag first.
  task automatic test_tiebreaks();
    send_item(OP_PUSH, 16'h8000, 16'h0010, 32'h00000005);
    send_item(OP_PUSH, 16'h8000, 16'h0008, 32'hFFFFFFFF);
    send_item(OP_PUSH, 16'h8000, 16'h0008, 32'h00000001);
    send_item(OP_PUSH, 16'h8000, 16'h0008, 32'h00000001);
    repeat (5) send_item(OP_POP, 16'($urandom), 16'($urandom), $urandom);
  endtask

  // Fill to capacity, push into the full store, then empty it again.
  task automatic test_full_store();
    while (held_keys.size() < DEPTH) send_random_push();
    send_item(OP_PUSH, 16'hFFFF, 16'h0000, 32'h0);
    send_item(OP_PUSH, 16'h0000, 16'hFFFF, 32'hFFFFFFFF);
    send_item(OP_PEEK, 16'h0, 16'h0, 32'h0);
    while (held_keys.size() > 0)
      send_item(OP_POP, 16'($urandom), 16'($urandom), $urandom);
    send_item(OP_POP, 16'h0, 16'h0, 32'h0);
  endtask

  // Random mix; the push bias drifts so the fill level sweeps up and down.
  task automatic test_random_mix(int count);
    int push_pct;
    int r;
    logic [15:0] sc;
    for (int i = 0; i < count; i++) begin
      if (i % 200 == 0) push_pct = $urandom_range(25, 80);
      if (i % 300 == 0) begin
        recv_stall_on = $urandom_range(0, 3) != 0;
        send_gap_on   = $urandom_range(0, 3) != 0;
      end
      r = $urandom_range(0, 99);
      // Narrow score range now and then to force tie-breaking.
      sc = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
      if (r < push_pct)
        send_item(OP_PUSH, sc, ($urandom_range(0, 1) ? 16'($urandom_range(0, 3)) : 16'($urandom)),
                  $urandom);
      else if (r < push_pct + (100 - push_pct) * 2 / 3)
        send_item(OP_POP, 16'($urandom), 16'($urandom), $urandom);
      else
        send_item(($urandom_range(0, 3) == 0) ? OP_RSVD : OP_PEEK, 16'($urandom),
                  16'($urandom), $urandom);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_and_extremes();
    test_tiebreaks();
    test_full_store();
    test_random_mix(1316);
    s_axis_tvalid <= 1'b0;
    drain();
    repeat (TAIL_WAIT) @(posedge clk);
    $display("Covered %0d items, %0d results (%0d empty, %0d full-drop reports)",
             sent, received, empty_hits, full_hits);
    $display("Mismatch count: %0d, outstanding: %0d", errors, pending_tops.size());
    if (errors == 0 && pending_tops.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
